### hdl/hbp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbp_pkg
// Shared types, codes and constants of the code-table bit packer.
// ----------------------------------------------------------------------------
package hbp_pkg;

	// default table shape
	localparam int MAX_CODE_LEN_DEF = 64;
	localparam int SYMBOL_COUNT_DEF = 256;

	// bits in one output byte, and the fill level that completes one
	localparam int         BYTE_BITS  = 8;
	localparam logic [3:0] FULL_COUNT = 4'd8;

	// widths of the stream fields
	localparam int SYMBOL_W   = 8;
	localparam int CODE_IN_W  = 64;
	localparam int LEN_IN_W   = 7;
	localparam int S_DATA_W   = 80;
	localparam int M_DATA_W   = 16;

	// operation codes carried in the input tuser
	typedef enum logic [1:0] {
		OP_LOAD   = 2'd0,
		OP_ENCODE = 2'd1,
		OP_FLUSH  = 2'd2,
		OP_CLEAR  = 2'd3
	} hbp_op_t;

	// result status carried in the output tuser
	localparam logic STATUS_DATA    = 1'b0;
	localparam logic STATUS_UNKNOWN = 1'b1;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_EMIT,
		ST_ERR,
		ST_FLUSH
	} hbp_state_t;

	// one result word headed for the output register
	typedef struct packed {
		logic       push;
		logic [7:0] out_byte;
		logic [3:0] valid_bits;
		logic       status;
		logic       last;
	} hbp_result_t;

	// mask of the lowest n bits of a byte, n up to 8
	function automatic logic [7:0] byte_mask(logic [3:0] n);
		logic [7:0] m;
		for (int i = 0; i < BYTE_BITS; i++) begin
			m[i] = (4'(i) < n);
		end
		return m;
	endfunction

endpackage

### hdl/hbp_code_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbp_code_ram
// Single-port-write, single-port-read synchronous RAM holding code and length
// of each table entry; read data is registered.
// ----------------------------------------------------------------------------
module hbp_code_ram #(
	parameter int DEPTH  = hbp_pkg::SYMBOL_COUNT_DEF,
	parameter int WIDTH  = hbp_pkg::MAX_CODE_LEN_DEF + 7,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### hdl/huffman_table_bit_packer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huffman_table_bit_packer_unit
// Code-table bit packer: loads and clears a symbol code table, packs codes of
// encoded symbols lsb first into bytes and emits completed and flushed bytes.
//
//  channel   dir  tdata                                        tuser       tlast
//  s_axis    in   symbol, code_bits, code_length (80 bits)     opcode      -
//  m_axis    out  out_byte, valid_bits (16 bits)               status      last
//
// load and clear complete in the idle state; flush and unknown symbol each push
// one word from their own state. encode takes the registered table read in the
// read state and packs chunks, at most one output word per cycle unless stalled.
// reset clears the entry valid flags at once; no clearing pass is needed.
// a stalled output register holds the sequencer only when a word must be
// pushed; load and clear go on while a result waits.
// ----------------------------------------------------------------------------
module huffman_table_bit_packer_unit #(
	parameter int MAX_CODE_LEN = hbp_pkg::MAX_CODE_LEN_DEF,
	parameter int SYMBOL_COUNT = hbp_pkg::SYMBOL_COUNT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// symbol [7:0], code_bits [71:8], code_length [78:72], zero [79]
	input  logic [hbp_pkg::S_DATA_W-1:0]  s_axis_tdata,
	// opcode [1:0]
	input  logic [1:0]                    s_axis_tuser,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// out_byte [7:0], valid_bits [11:8], zero [15:12]
	output logic [hbp_pkg::M_DATA_W-1:0]  m_axis_tdata,
	// status [0]
	output logic [0:0]                    m_axis_tuser,
	output logic                          m_axis_tlast
);

	localparam int IDX_W   = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
	localparam int LEN_W   = $clog2(MAX_CODE_LEN + 1);
	localparam int ENTRY_W = MAX_CODE_LEN + LEN_W;

	// input field split
	hbp_pkg::hbp_op_t                 op;
	logic [hbp_pkg::SYMBOL_W-1:0]     sym;
	logic [hbp_pkg::CODE_IN_W-1:0]    code_in;
	logic [hbp_pkg::LEN_IN_W-1:0]     len_in;
	logic [IDX_W-1:0]                 sym_idx;
	logic                             in_range;
	logic                             known;
	logic                             accept;
	logic [LEN_W-1:0]                 len_clamped;

	assign op       = hbp_pkg::hbp_op_t'(s_axis_tuser);
	assign sym      = s_axis_tdata[7:0];
	assign code_in  = s_axis_tdata[71:8];
	assign len_in   = s_axis_tdata[78:72];
	assign sym_idx  = sym[IDX_W-1:0];
	assign in_range = ({1'b0, sym} < 9'(SYMBOL_COUNT));
	assign accept   = s_axis_tvalid && s_axis_tready;

	// overlong codes are cut to the stored maximum
	assign len_clamped = (len_in > 7'(MAX_CODE_LEN)) ? LEN_W'(MAX_CODE_LEN)
	                                                 : LEN_W'(len_in);

	// state registers
	hbp_pkg::hbp_state_t         state_q, state_d;
	logic [SYMBOL_COUNT-1:0]     valid_q;
	logic [6:0]                  partial_q;
	logic [2:0]                  fill_q;
	logic [MAX_CODE_LEN-1:0]     code_q;
	logic [LEN_W-1:0]            left_q;

	assign known = in_range && valid_q[sym_idx];

	// output register
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic [3:0] out_bits_q;
	logic       out_status_q;
	logic       out_last_q;
	logic       out_free;

	assign out_free = !out_valid_q || m_axis_tready;

	// code table memory
	logic               ram_we;
	logic               ram_re;
	logic [ENTRY_W-1:0] ram_wdata;
	logic [ENTRY_W-1:0] ram_rdata;

	assign ram_wdata = {len_clamped, code_in[MAX_CODE_LEN-1:0]};

	hbp_code_ram #(
		.DEPTH  (SYMBOL_COUNT),
		.WIDTH  (ENTRY_W),
		.ADDR_W (IDX_W)
	) u_code_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (sym_idx),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (sym_idx),
		.rdata (ram_rdata)
	);

	// one packing step: take up to the free room of the partial byte
	logic [3:0]       room;
	logic [3:0]       take;
	logic [3:0]       n_new;
	logic [LEN_W-1:0] left_new;
	logic [7:0]       chunk;
	logic [7:0]       acc;
	logic             step_full;
	logic             step_last;

	always_comb begin
		room      = hbp_pkg::FULL_COUNT - {1'b0, fill_q};
		take      = (left_q < LEN_W'(room)) ? left_q[3:0] : room;
		n_new     = {1'b0, fill_q} + take;
		left_new  = left_q - LEN_W'(take);
		chunk     = code_q[7:0] & hbp_pkg::byte_mask(take);
		acc       = {1'b0, partial_q} | 8'(chunk << fill_q);
		step_full = (n_new == hbp_pkg::FULL_COUNT);
		step_last = (left_new < LEN_W'(hbp_pkg::BYTE_BITS));
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			hbp_pkg::ST_IDLE: begin
				if (accept) begin
					unique case (op)
						hbp_pkg::OP_ENCODE: state_d = known ? hbp_pkg::ST_READ
						                                    : hbp_pkg::ST_ERR;
						hbp_pkg::OP_FLUSH:  state_d = hbp_pkg::ST_FLUSH;
						default:            state_d = hbp_pkg::ST_IDLE;
					endcase
				end
			end
			hbp_pkg::ST_READ: state_d = hbp_pkg::ST_EMIT;
			hbp_pkg::ST_EMIT: begin
				if (left_q == '0) begin
					state_d = hbp_pkg::ST_IDLE;
				end else if ((!step_full || out_free) && left_new == '0) begin
					state_d = hbp_pkg::ST_IDLE;
				end
			end
			hbp_pkg::ST_ERR,
			hbp_pkg::ST_FLUSH: begin
				if (out_free) begin
					state_d = hbp_pkg::ST_IDLE;
				end
			end
			default: state_d = hbp_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs
	hbp_pkg::hbp_result_t res;
	logic                 step_en;

	always_comb begin
		s_axis_tready = 1'b0;
		ram_we        = 1'b0;
		ram_re        = 1'b0;
		step_en       = 1'b0;
		res           = '0;
		unique case (state_q)
			hbp_pkg::ST_IDLE: begin
				s_axis_tready = 1'b1;
				ram_we        = s_axis_tvalid && op == hbp_pkg::OP_LOAD && in_range;
				ram_re        = s_axis_tvalid && op == hbp_pkg::OP_ENCODE && known;
			end
			hbp_pkg::ST_READ: ;
			hbp_pkg::ST_EMIT: begin
				step_en = (left_q != '0) && (!step_full || out_free);
				if (step_en && step_full) begin
					res.push       = 1'b1;
					res.out_byte   = acc;
					res.valid_bits = hbp_pkg::FULL_COUNT;
					res.status     = hbp_pkg::STATUS_DATA;
					res.last       = step_last;
				end
			end
			hbp_pkg::ST_ERR: begin
				res.push   = out_free;
				res.status = hbp_pkg::STATUS_UNKNOWN;
				res.last   = 1'b1;
			end
			hbp_pkg::ST_FLUSH: begin
				res.push       = out_free;
				res.out_byte   = {1'b0, partial_q};
				res.valid_bits = {1'b0, fill_q};
				res.status     = hbp_pkg::STATUS_DATA;
				res.last       = 1'b1;
			end
			default: ;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= hbp_pkg::ST_IDLE;
			valid_q   <= '0;
			partial_q <= '0;
			fill_q    <= '0;
		end else begin
			state_q <= state_d;
			// entry valid flags
			if (accept && op == hbp_pkg::OP_CLEAR) begin
				valid_q <= '0;
			end else if (ram_we) begin
				valid_q[sym_idx] <= 1'b1;
			end
			// held partial byte
			if (step_en) begin
				partial_q <= step_full ? 7'd0 : acc[6:0];
				fill_q    <= step_full ? 3'd0 : n_new[2:0];
			end else if (state_q == hbp_pkg::ST_FLUSH && out_free) begin
				partial_q <= '0;
				fill_q    <= '0;
			end
		end
	end

	// code shift register loaded from the table read
	always_ff @(posedge clk) begin
		if (state_q == hbp_pkg::ST_READ) begin
			code_q <= ram_rdata[MAX_CODE_LEN-1:0];
			left_q <= ram_rdata[ENTRY_W-1:MAX_CODE_LEN];
		end else if (step_en) begin
			code_q <= code_q >> take;
			left_q <= left_new;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.push) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register word
	always_ff @(posedge clk) begin
		if (res.push) begin
			out_byte_q   <= res.out_byte;
			out_bits_q   <= res.valid_bits;
			out_status_q <= res.status;
			out_last_q   <= res.last;
		end
	end

	assign m_axis_tvalid   = out_valid_q;
	assign m_axis_tdata    = {4'd0, out_bits_q, out_byte_q};
	assign m_axis_tuser[0] = out_status_q;
	assign m_axis_tlast    = out_last_q;

	// held bits above the fill level stay clear
	a_partial_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(({1'b0, partial_q} >> fill_q) == 8'd0))
		else $error("partial byte has bits above fill level");

	// a known encode goes to the table read
	a_encode_read: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && op == hbp_pkg::OP_ENCODE && known) |=> state_q == hbp_pkg::ST_READ)
		else $error("encode did not start table read");

	// a delivered flush leaves nothing held
	a_flush_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == hbp_pkg::ST_FLUSH && out_free) |=> (fill_q == 3'd0 && partial_q == 7'd0))
		else $error("flush left bits held");

	// an unknown symbol word is empty and last
	a_error_word: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tlast && m_axis_tdata[11:0] == 12'd0))
		else $error("malformed unknown symbol word");

endmodule

### tb/tb_huffman_table_bit_packer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_huffman_table_bit_packer_unit
// Self-checking bench for the code-table bit packer. Table loads, clears,
// encodes and flushes go in on the input stream; a predictor in the bench
// keeps its own table and held bits and queues the bytes each word should
// give. A checker on the output stream compares each byte word with the
// oldest queued one. Directed code extremes and unknown symbols after a clear
// come first, then random traffic under three idling mixes on the two sides.
// ----------------------------------------------------------------------------
module tb_huffman_table_bit_packer_unit;

	localparam int CODE_MAX    = hbp_pkg::MAX_CODE_LEN_DEF;
	localparam int TABLE_SIZE  = hbp_pkg::SYMBOL_COUNT_DEF;
	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_TAIL  = 16;

	// one expected output word
	typedef struct packed {
		logic [7:0] out_byte;
		logic [3:0] valid_bits;
		logic       status;
		logic       last;
	} byte_word_t;

	logic                           clk;
	logic                           arst_n        = 1'b0;
	logic                           s_axis_tvalid = 1'b0;
	logic                           s_axis_tready;
	// symbol [7:0], code_bits [71:8], code_length [78:72], zero [79]
	logic [hbp_pkg::S_DATA_W-1:0]   s_axis_tdata  = '0;
	// opcode [1:0]
	logic [1:0]                     s_axis_tuser  = hbp_pkg::OP_FLUSH;
	logic                           m_axis_tvalid;
	logic                           m_axis_tready = 1'b0;
	// out_byte [7:0], valid_bits [11:8], zero [15:12]
	logic [hbp_pkg::M_DATA_W-1:0]   m_axis_tdata;
	// status [0]
	logic [0:0]                     m_axis_tuser;
	logic                           m_axis_tlast;

	// predictor state
	logic [63:0] tab_code [TABLE_SIZE];
	logic [6:0]  tab_len  [TABLE_SIZE];
	logic        tab_live [TABLE_SIZE];
	logic        tab_written [TABLE_SIZE];
	logic [7:0]  held_bits;
	logic [3:0]  held_count;
	logic [7:0]  known_syms [$];
	byte_word_t  byte_queue [$];

	int src_idle = 0;
	int dst_idle = 0;
	int err_count = 0;
	int stall_cycles = 0;
	int words_in [4];
	int words_out = 0;
	int unknown_out = 0;
	int flush_out = 0;

	huffman_table_bit_packer_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// append one expected word at the tail of the queue
	function automatic void queue_word(byte_word_t w);
		byte_queue.insert(byte_queue.size(), w);
	endfunction

	// update the table copy and queue the words one input word gives
	function automatic void advance_packer(hbp_pkg::hbp_op_t op, logic [7:0] sym,
			logic [63:0] code, logic [6:0] len);
		logic [6:0] clipped;
		int         first;
		byte_word_t w;
		clipped = (int'(len) > CODE_MAX) ? 7'(CODE_MAX) : len;
		first = byte_queue.size();
		case (op)
			hbp_pkg::OP_LOAD: begin
				if (int'(sym) < TABLE_SIZE) begin
					tab_code[sym] = (int'(clipped) >= 64) ? code
						: code & ((64'd1 << clipped) - 64'd1);
					tab_len[sym]  = clipped;
					tab_live[sym] = 1'b1;
				end
			end
			hbp_pkg::OP_CLEAR: begin
				for (int i = 0; i < TABLE_SIZE; i++) tab_live[i] = 1'b0;
			end
			hbp_pkg::OP_FLUSH: begin
				queue_word(byte_word_t'{held_bits, held_count, hbp_pkg::STATUS_DATA, 1'b1});
				held_bits  = '0;
				held_count = '0;
			end
			default: begin
				if (int'(sym) >= TABLE_SIZE || !tab_live[sym]) begin
					queue_word(byte_word_t'{8'd0, 4'd0, hbp_pkg::STATUS_UNKNOWN, 1'b1});
				end else begin
					// pack lsb first, one byte out per eight bits
					for (int i = 0; i < int'(tab_len[sym]); i++) begin
						held_bits[held_count[2:0]] = tab_code[sym][i];
						held_count++;
						if (held_count == hbp_pkg::FULL_COUNT) begin
							queue_word(byte_word_t'{held_bits, hbp_pkg::FULL_COUNT,
								hbp_pkg::STATUS_DATA, 1'b0});
							held_bits  = '0;
							held_count = '0;
						end
					end
					if (byte_queue.size() > first) begin
						w = byte_queue.pop_back();
						w.last = 1'b1;
						queue_word(w);
					end
				end
			end
		endcase
	endfunction

	// offer one input word, with a random gap first; valid stays high on return
	task automatic send_word(input hbp_pkg::hbp_op_t op, input logic [7:0] sym,
			input logic [63:0] code, input logic [6:0] len);
		while ($urandom_range(0, 99) < src_idle) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= {1'b0, len, code, sym};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		advance_packer(op, sym, code, len);
		words_in[op]++;
		if (op == hbp_pkg::OP_LOAD && !tab_written[sym]) begin
			tab_written[sym] = 1'b1;
			known_syms.insert(known_syms.size(), sym);
		end
		@(negedge clk);
	endtask

	// hold the input until every queued word has come out
	task automatic wait_for_drain();
		s_axis_tvalid <= 1'b0;
		while (byte_queue.size() != 0) @(negedge clk);
		repeat (DRAIN_TAIL) @(negedge clk);
	endtask

	// extremes of code length and code bits, zero-length and overlong codes
	task automatic test_code_extremes();
		send_word(hbp_pkg::OP_FLUSH, 8'h00, 64'd0, 7'd0);
		send_word(hbp_pkg::OP_LOAD, 8'h00, 64'hFFFF_FFFF_FFFF_FFFF, 7'd64);
		send_word(hbp_pkg::OP_LOAD, 8'hFF, 64'hFFFF_FFFF_FFFF_FFF5, 7'd3);
		send_word(hbp_pkg::OP_LOAD, 8'hA5, 64'h0, 7'd0);
		send_word(hbp_pkg::OP_LOAD, 8'h5A, 64'hFFFF_FFFF_FFFF_FFFF, 7'd127);
		send_word(hbp_pkg::OP_LOAD, 8'h3C, 64'h0123_4567_89AB_CDEF, 7'd65);
		// three bits, no full byte
		send_word(hbp_pkg::OP_ENCODE, 8'hFF, 64'd0, 7'd0);
		// 64 bits on top of three held: eight bytes
		send_word(hbp_pkg::OP_ENCODE, 8'h00, 64'd0, 7'd0);
		send_word(hbp_pkg::OP_ENCODE, 8'hA5, 64'd0, 7'd0);
		send_word(hbp_pkg::OP_FLUSH, 8'h00, 64'd0, 7'd0);
		send_word(hbp_pkg::OP_ENCODE, 8'h5A, 64'd0, 7'd0);
		send_word(hbp_pkg::OP_ENCODE, 8'h3C, 64'd0, 7'd0);
		send_word(hbp_pkg::OP_FLUSH, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF, 7'd127);
		wait_for_drain();
	endtask

	// unknown symbols after a clear keep the held bits
	task automatic test_unknown_after_clear();
		send_word(hbp_pkg::OP_LOAD, 8'h81, 64'h0000_0000_0000_00C3, 7'd8);
		send_word(hbp_pkg::OP_ENCODE, 8'hFF, 64'd0, 7'd0);
		send_word(hbp_pkg::OP_ENCODE, 8'h81, 64'd0, 7'd0);
		send_word(hbp_pkg::OP_CLEAR, 8'h00, 64'd0, 7'd0);
		send_word(hbp_pkg::OP_ENCODE, 8'h00, 64'd0, 7'd0);
		send_word(hbp_pkg::OP_ENCODE, 8'hFF, 64'd0, 7'd0);
		send_word(hbp_pkg::OP_FLUSH, 8'h00, 64'd0, 7'd0);
		send_word(hbp_pkg::OP_LOAD, 8'h42, 64'h1, 7'd1);
		send_word(hbp_pkg::OP_ENCODE, 8'h42, 64'd0, 7'd0);
		send_word(hbp_pkg::OP_ENCODE, 8'h81, 64'd0, 7'd0);
		send_word(hbp_pkg::OP_FLUSH, 8'h00, 64'd0, 7'd0);
	endtask

	// mostly loads followed by encodes of loaded symbols, some noise
	task automatic test_random_traffic(input int n, input int src_pct, input int dst_pct);
		logic [7:0]  sym;
		logic [63:0] code;
		logic [6:0]  len;
		int          r;
		int          r2;
		src_idle = src_pct;
		dst_idle = dst_pct;
		for (int k = 0; k < n; k++) begin
			if (k == n / 2) wait_for_drain();
			r    = $urandom_range(0, 99);
			r2   = $urandom_range(0, 99);
			code = {$urandom, $urandom};
			if (r2 < 6)       len = 7'd0;
			else if (r2 < 70) len = 7'($urandom_range(1, 12));
			else if (r2 < 90) len = 7'($urandom_range(13, 64));
			else              len = 7'($urandom_range(65, 127));
			sym = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
				: 8'($urandom_range(0, 31));
			if (r < 62 && known_syms.size() > 0) begin
				// encode only entries written at some point
				sym = known_syms[$urandom_range(0, known_syms.size() - 1)];
				if (tab_live[sym] || $urandom_range(0, 3) == 0)
					send_word(hbp_pkg::OP_ENCODE, sym, code, len);
				else
					send_word(hbp_pkg::OP_LOAD, sym, code, len);
			end else if (r < 80) begin
				send_word(hbp_pkg::OP_LOAD, sym, code, len);
			end else if (r < 97) begin
				send_word(hbp_pkg::OP_FLUSH, sym, code, len);
			end else begin
				send_word(hbp_pkg::OP_CLEAR, sym, code, len);
			end
		end
	endtask

	// output stall pattern
	always @(negedge clk) begin
		m_axis_tready <= ($urandom_range(0, 99) >= dst_idle);
	end

	// result checker and stall watchdog
	always @(posedge clk) begin
		byte_word_t exp_w;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			words_out++;
			if (byte_queue.size() == 0) begin
				$error("unexpected word: out_byte %0h valid_bits %0d status %0d last %0d",
					m_axis_tdata[7:0], m_axis_tdata[11:8], m_axis_tuser[0], m_axis_tlast);
				err_count++;
			end else begin
				exp_w = byte_queue.pop_front();
				if (exp_w.status == hbp_pkg::STATUS_UNKNOWN) unknown_out++;
				else if (exp_w.valid_bits != hbp_pkg::FULL_COUNT) flush_out++;
				if (m_axis_tdata[7:0] !== exp_w.out_byte) begin
					$error("out_byte: expected %0h, got %0h", exp_w.out_byte, m_axis_tdata[7:0]);
					err_count++;
				end
				if (m_axis_tdata[11:8] !== exp_w.valid_bits) begin
					$error("valid_bits: expected %0d, got %0d", exp_w.valid_bits,
						m_axis_tdata[11:8]);
					err_count++;
				end
				if (m_axis_tuser[0] !== exp_w.status) begin
					$error("status: expected %0d, got %0d", exp_w.status, m_axis_tuser[0]);
					err_count++;
				end
				if (m_axis_tlast !== exp_w.last) begin
					$error("last: expected %0d, got %0d", exp_w.last, m_axis_tlast);
					err_count++;
				end
			end
		end
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("timeout: no word moved for %0d cycles", STALL_LIMIT);
			$display("tb: failure");
			$finish;
		end
	end

	// test sequence
	initial begin
		for (int i = 0; i < TABLE_SIZE; i++) begin
			tab_live[i]    = 1'b0;
			tab_written[i] = 1'b0;
		end
		for (int i = 0; i < 4; i++) words_in[i] = 0;
		held_bits  = '0;
		held_count = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		src_idle = 11;
		dst_idle = 61;
		test_code_extremes();
		test_unknown_after_clear();
		test_random_traffic(99, 11, 61);
		test_random_traffic(99, 61, 11);
		test_random_traffic(99, 0, 0);
		wait_for_drain();

		$display("covered %0d loads, %0d encodes, %0d flushes, %0d clears",
			words_in[hbp_pkg::OP_LOAD], words_in[hbp_pkg::OP_ENCODE],
			words_in[hbp_pkg::OP_FLUSH], words_in[hbp_pkg::OP_CLEAR]);
		$display("checked %0d output words: %0d flush words, %0d unknown symbols",
			words_out, flush_out, unknown_out);
		if (err_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

### huffman_table_bit_packer_unit.f
hdl/hbp_pkg.sv
hdl/hbp_code_ram.sv
hdl/huffman_table_bit_packer_unit.sv
tb/tb_huffman_table_bit_packer_unit.sv
